// ===== sv/bcvm_pkg.sv =====
// Package with constants, types and helper functions of the byte-code execute unit.
`default_nettype none
package bcvm_pkg;

    localparam int DATA_BYTES = 4096;
    localparam int ADDR_W     = $clog2(DATA_BYTES);
    localparam int BANKS      = 4;
    localparam int ROWS       = DATA_BYTES / BANKS;
    localparam int ROW_W      = ADDR_W - 2;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);

    localparam logic [7:0] OP_MOV  = 8'h50;
    localparam logic [7:0] OP_LEA  = 8'h51;
    localparam logic [7:0] OP_ADD  = 8'h20;
    localparam logic [7:0] OP_SUB  = 8'h21;
    localparam logic [7:0] OP_XOR  = 8'h22;
    localparam logic [7:0] OP_AND  = 8'h23;
    localparam logic [7:0] OP_OR   = 8'h24;
    localparam logic [7:0] OP_NOT  = 8'h25;
    localparam logic [7:0] OP_INC  = 8'h30;
    localparam logic [7:0] OP_DEC  = 8'h31;
    localparam logic [7:0] OP_CMP  = 8'h32;
    localparam logic [7:0] OP_JMP  = 8'h40;
    localparam logic [7:0] OP_JZ   = 8'h41;
    localparam logic [7:0] OP_JNZ  = 8'h42;
    localparam logic [7:0] OP_JH   = 8'h43;
    localparam logic [7:0] OP_JL   = 8'h44;
    localparam logic [7:0] OP_NOP  = 8'h5F;
    localparam logic [7:0] OP_INT  = 8'hE0;

    localparam logic [7:0] MODE_RR  = 8'd0;
    localparam logic [7:0] MODE_RI  = 8'd1;
    localparam logic [7:0] MODE_RM  = 8'd2;
    localparam logic [7:0] MODE_MR  = 8'd3;
    localparam logic [7:0] MODE_MM  = 8'd4;
    localparam logic [7:0] MODE_REG = 8'd5;
    localparam logic [7:0] MODE_IMM = 8'd6;

    localparam logic [3:0] W_BYTE = 4'd0;
    localparam logic [3:0] W_HALF = 4'd1;
    localparam logic [3:0] W_WORD = 4'd2;

    typedef enum logic [3:0] {
        C_HOST,
        C_MOV_RR,
        C_MOV_RI,
        C_MOV_RM,
        C_MOV_MR,
        C_LEA_RR,
        C_LEA_RI,
        C_INT,
        C_JUMP,
        C_ALU,
        C_CMP_RI,
        C_NOP,
        C_BAD
    } cls_t;

    typedef enum logic [2:0] {
        A_ADD, A_SUB, A_XOR, A_AND, A_OR, A_INC, A_DEC, A_NOT
    } alu_op_t;

    typedef enum logic [2:0] {
        J_ALWAYS, J_Z, J_NZ, J_H, J_L
    } jcond_t;

    typedef enum logic {
        BK_EXEC,
        BK_WAIT
    } bk_state_t;

    typedef struct packed {
        cls_t              cls;
        alu_op_t           alu_op;
        jcond_t            jcond;
        logic              use_imm;
        logic [2:0]        mode;
        logic [3:0]        ra;
        logic [3:0]        wa;
        logic [3:0]        rb;
        logic [3:0]        wb;
        logic [2:0]        len;
        logic [ADDR_W-1:0] load_address;
        logic [31:0]       imm;
    } item_t;

    typedef struct packed {
        logic        clearing;
        logic [31:0] ip;
    } bk_status_t;

    // Mask for a byte, half or word access.
    function automatic logic [31:0] width_mask(input logic [3:0] w);
        logic [31:0] m;
        if (w == W_BYTE)
        begin
            m = 32'h0000_00FF;
        end
        else if (w == W_HALF)
        begin
            m = 32'h0000_FFFF;
        end
        else
        begin
            m = 32'hFFFF_FFFF;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== sv/bcvm_if.sv =====
// Channel interfaces for instruction items and result items.
`default_nettype none
interface bcvm_in_if;
    logic        valid;
    logic        ready;
    logic        host_load;
    logic [11:0] load_address;
    logic [7:0]  opcode;
    logic [7:0]  mode;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [31:0] immediate;

    modport source (output valid, host_load, load_address, opcode, mode, operand_a,
                    operand_b, immediate, input ready);
    modport sink (input valid, host_load, load_address, opcode, mode, operand_a,
                  operand_b, immediate, output ready);
endinterface

interface bcvm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_ip;
    logic        fault;
    logic        service_request;
    logic [7:0]  service_number;
    logic [31:0] service_argument;
    logic        zero_out;
    logic        positive_out;

    modport source (output valid, next_ip, fault, service_request, service_number,
                    service_argument, zero_out, positive_out, input ready);
    modport sink (input valid, next_ip, fault, service_request, service_number,
                  service_argument, zero_out, positive_out, output ready);
endinterface
`default_nettype wire

// ===== sv/bcvm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bcvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/bcvm_front.sv =====
// Front end: accepts items and decodes them into classified queue entries.
`default_nettype none
module bcvm_front (
    bcvm_in_if.sink             req,
    input  wire logic           blocked,
    input  wire logic           q_full,
    output logic                push,
    output bcvm_pkg::item_t     push_item
);
    import bcvm_pkg::*;

    logic [2:0] mode_len;

    // Accept whenever the queue has room and the memory is not being cleared.
    assign req.ready = !blocked && !q_full;
    assign push      = req.valid && req.ready;

    // Instruction length for modes zero through six.
    always_comb
    begin
        unique case (req.mode[2:0])
            3'd0:    mode_len = 3'd4;
            3'd1:    mode_len = 3'd7;
            3'd5:    mode_len = 3'd3;
            3'd6:    mode_len = 3'd6;
            default: mode_len = 3'd4;
        endcase
    end

    // Classification of the item, with all static faults folded into one class.
    always_comb
    begin
        push_item              = '0;
        push_item.cls          = C_BAD;
        push_item.alu_op       = A_ADD;
        push_item.jcond        = J_ALWAYS;
        push_item.mode         = req.mode[2:0];
        push_item.ra           = req.operand_a[7:4];
        push_item.wa           = req.operand_a[3:0];
        push_item.rb           = req.operand_b[7:4];
        push_item.wb           = req.operand_b[3:0];
        push_item.imm          = req.immediate;
        push_item.load_address = req.load_address[ADDR_W-1:0];
        push_item.len          = mode_len;
        push_item.use_imm      = (req.mode == MODE_RI);
        if (req.host_load)
        begin
            push_item.cls = C_HOST;
        end
        else
        begin
            unique case (req.opcode)
                OP_MOV, OP_LEA:
                begin
                    if (req.mode == MODE_RR)
                    begin
                        if (req.operand_a[3:0] <= W_WORD)
                        begin
                            push_item.cls = (req.opcode == OP_MOV) ? C_MOV_RR : C_LEA_RR;
                        end
                        else if (req.opcode == OP_LEA)
                        begin
                            push_item.cls = C_NOP;
                        end
                    end
                    else if (req.mode == MODE_RI)
                    begin
                        if (req.operand_a[3:0] <= W_WORD)
                        begin
                            push_item.cls = (req.opcode == OP_MOV) ? C_MOV_RI : C_LEA_RI;
                        end
                    end
                    else if (req.mode == MODE_RM && req.opcode == OP_MOV)
                    begin
                        if (req.operand_a[3:0] <= W_WORD)
                        begin
                            push_item.cls = C_MOV_RM;
                        end
                    end
                    else if (req.mode == MODE_MR && req.opcode == OP_MOV)
                    begin
                        if (req.operand_b[3:0] <= W_WORD)
                        begin
                            push_item.cls = C_MOV_MR;
                        end
                    end
                end
                OP_INT:
                begin
                    push_item.cls = C_INT;
                    push_item.len = 3'd2;
                end
                OP_JMP, OP_JZ, OP_JNZ, OP_JH, OP_JL:
                begin
                    if (req.mode <= MODE_IMM)
                    begin
                        push_item.cls = C_JUMP;
                    end
                    unique case (req.opcode)
                        OP_JZ:   push_item.jcond = J_Z;
                        OP_JNZ:  push_item.jcond = J_NZ;
                        OP_JH:   push_item.jcond = J_H;
                        OP_JL:   push_item.jcond = J_L;
                        default: push_item.jcond = J_ALWAYS;
                    endcase
                end
                OP_INC, OP_DEC, OP_NOT:
                begin
                    if (req.operand_a[3:0] <= W_WORD)
                    begin
                        push_item.cls = C_ALU;
                    end
                    push_item.len = 3'd2;
                    unique case (req.opcode)
                        OP_INC:  push_item.alu_op = A_INC;
                        OP_DEC:  push_item.alu_op = A_DEC;
                        default: push_item.alu_op = A_NOT;
                    endcase
                end
                OP_CMP:
                begin
                    if (req.mode == MODE_RR)
                    begin
                        push_item.cls = C_NOP;
                        push_item.len = 3'd4;
                    end
                    else if (req.mode == MODE_RI)
                    begin
                        push_item.cls = C_CMP_RI;
                        push_item.len = 3'd7;
                    end
                end
                OP_ADD, OP_SUB, OP_XOR, OP_AND, OP_OR:
                begin
                    if (req.mode <= MODE_RI && req.operand_a[3:0] <= W_WORD)
                    begin
                        push_item.cls = C_ALU;
                    end
                    unique case (req.opcode)
                        OP_ADD:  push_item.alu_op = A_ADD;
                        OP_SUB:  push_item.alu_op = A_SUB;
                        OP_XOR:  push_item.alu_op = A_XOR;
                        OP_AND:  push_item.alu_op = A_AND;
                        default: push_item.alu_op = A_OR;
                    endcase
                end
                OP_NOP:
                begin
                    push_item.cls = C_NOP;
                    push_item.len = 3'd1;
                end
                default:
                begin
                    push_item.cls = C_BAD;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/bcvm_queue.sv =====
// Two-entry queue between the decode front end and the execute back end.
`default_nettype none
module bcvm_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bcvm_pkg::item_t  push_item,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output bcvm_pkg::item_t       head_item
);
    import bcvm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// ===== sv/bcvm_back.sv =====
// Back end: register file, flags, banked data memory and result register.
`default_nettype none
module bcvm_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire bcvm_pkg::item_t  head_item,
    output logic                  pop,
    output bcvm_pkg::bk_status_t  status,
    bcvm_out_if.source            rsp
);
    import bcvm_pkg::*;

    logic [31:0]      rf_reg [NUM_REGS];
    logic [31:0]      ip_reg;
    logic             zf_reg;
    logic             pf_reg;
    logic             clearing_reg;
    logic [ROW_W-1:0] clr_row_reg;
    bk_state_t        state_reg;
    bk_state_t        state_next;

    logic             out_valid_reg;
    logic [31:0]      out_ip_reg;
    logic             out_fault_reg;
    logic             out_sreq_reg;
    logic [7:0]       out_snum_reg;
    logic [31:0]      out_sarg_reg;
    logic             out_zf_reg;
    logic             out_pf_reg;

    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] r0;
    logic [31:0] r3;
    logic [31:0] opnd;
    logic [31:0] alu_r;
    logic [31:0] loaded;
    logic [31:0] target;
    logic [31:0] ip_next;
    logic [31:0] flag_val;
    logic [3:0]  flag_w;
    logic        set_fl;
    logic        zf_next;
    logic        pf_next;
    logic        rf_we;
    logic [31:0] rf_wval;
    logic        take;
    logic        jump;
    logic        bad;
    logic        sreq;
    logic        out_free;
    logic        commit;
    logic        rd_issue;
    logic [2:0]  nbytes;
    logic [ADDR_W-1:0] maddr;

    logic             bank_we    [BANKS];
    logic [ROW_W-1:0] bank_waddr [BANKS];
    logic [7:0]       bank_wdata [BANKS];
    logic [ROW_W-1:0] bank_raddr [BANKS];
    logic [7:0]       bank_rdata [BANKS];

    // Register read with out-of-range indexes reading as zero.
    function automatic logic [31:0] rd_reg(input logic [31:0] rf [NUM_REGS],
                                           input logic [3:0] idx);
        logic [31:0] v;
        v = '0;
        if ({1'b0, idx} < 5'(NUM_REGS))
        begin
            v = rf[idx[REG_IDX_W-1:0]];
        end
        return v;
    endfunction

    assign x  = rd_reg(rf_reg, head_item.ra);
    assign y  = rd_reg(rf_reg, head_item.rb);
    assign r0 = rd_reg(rf_reg, 4'd0);
    assign r3 = rd_reg(rf_reg, 4'd3);

    assign out_free = !out_valid_reg || rsp.ready;
    assign commit   = head_valid && out_free &&
                      (head_item.cls != C_MOV_RM || state_reg == BK_WAIT);
    assign pop      = commit;

    // Memory address: the load reads through B, the store writes through A.
    assign maddr  = (head_item.cls == C_MOV_RM) ? y[ADDR_W-1:0] : x[ADDR_W-1:0];
    assign nbytes = (head_item.wb == W_BYTE) ? 3'd1 : ((head_item.wb == W_HALF) ? 3'd2 : 3'd4);

    // Next state of the load sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_EXEC:
            begin
                if (head_valid && head_item.cls == C_MOV_RM)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (commit)
                begin
                    state_next = BK_EXEC;
                end
            end
            default: state_next = BK_EXEC;
        endcase
    end

    // Sequencer outputs: a load reads the banks once, then waits for the data.
    always_comb
    begin
        unique case (state_reg)
            BK_EXEC: rd_issue = head_valid && (head_item.cls == C_MOV_RM);
            BK_WAIT: rd_issue = 1'b0;
            default: rd_issue = 1'b0;
        endcase
    end

    // Gather the little-endian load word from the banks.
    always_comb
    begin
        for (int j = 0; j < BANKS; j++)
        begin
            loaded[8*j +: 8] = bank_rdata[2'(maddr[1:0] + 2'(j))];
        end
    end

    // ALU and compare.
    assign opnd = head_item.use_imm ? head_item.imm : y;
    always_comb
    begin
        unique case (head_item.alu_op)
            A_ADD:   alu_r = x + opnd;
            A_SUB:   alu_r = x - opnd;
            A_XOR:   alu_r = x ^ opnd;
            A_AND:   alu_r = x & opnd;
            A_OR:    alu_r = x | opnd;
            A_INC:   alu_r = x + 32'd1;
            A_DEC:   alu_r = x - 32'd1;
            default: alu_r = ~x;
        endcase
    end

    // Instruction effect on registers, flags and the instruction pointer.
    always_comb
    begin
        rf_we    = 1'b0;
        rf_wval  = '0;
        set_fl   = 1'b0;
        flag_w   = head_item.wa;
        flag_val = '0;
        jump     = 1'b0;
        bad      = 1'b0;
        sreq     = 1'b0;
        target   = '0;
        unique case (head_item.jcond)
            J_Z:     take = !zf_reg;
            J_NZ:    take = zf_reg;
            J_H:     take = pf_reg;
            J_L:     take = !pf_reg;
            default: take = 1'b1;
        endcase
        unique case (head_item.cls)
            C_MOV_RR, C_LEA_RR:
            begin
                rf_we    = 1'b1;
                rf_wval  = y & width_mask(head_item.wa);
                set_fl   = (head_item.cls == C_MOV_RR);
                flag_val = rf_wval;
            end
            C_MOV_RI, C_LEA_RI:
            begin
                rf_we    = 1'b1;
                rf_wval  = head_item.imm & width_mask(head_item.wa);
                set_fl   = 1'b1;
                flag_val = rf_wval;
            end
            C_MOV_RM:
            begin
                rf_we   = 1'b1;
                rf_wval = loaded & width_mask(head_item.wa);
            end
            C_ALU:
            begin
                rf_we    = 1'b1;
                rf_wval  = alu_r & width_mask(head_item.wa);
                set_fl   = 1'b1;
                flag_val = rf_wval;
            end
            C_CMP_RI:
            begin
                set_fl   = 1'b1;
                flag_w   = W_WORD;
                flag_val = x - {{24{head_item.imm[7]}}, head_item.imm[7:0]};
            end
            C_JUMP:
            begin
                if (take)
                begin
                    if (head_item.mode == MODE_REG[2:0])
                    begin
                        jump   = 1'b1;
                        target = x;
                    end
                    else if (head_item.mode == MODE_IMM[2:0])
                    begin
                        jump   = 1'b1;
                        target = head_item.imm;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
            end
            C_INT:
            begin
                sreq = 1'b1;
            end
            C_BAD:
            begin
                bad = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Flag update: zero clears Z and keeps P; nonzero sets Z and P from the sign.
    always_comb
    begin
        zf_next = zf_reg;
        pf_next = pf_reg;
        if (set_fl)
        begin
            if ((flag_val & width_mask(flag_w)) == '0)
            begin
                zf_next = 1'b0;
            end
            else
            begin
                zf_next = 1'b1;
                if (flag_w == W_BYTE)
                begin
                    pf_next = !flag_val[7];
                end
                else if (flag_w == W_HALF)
                begin
                    pf_next = !flag_val[15];
                end
                else
                begin
                    pf_next = !flag_val[31];
                end
            end
        end
    end

    // Next instruction pointer.
    always_comb
    begin
        if (bad || head_item.cls == C_HOST)
        begin
            ip_next = ip_reg;
        end
        else if (jump && target != ip_reg)
        begin
            ip_next = target;
        end
        else
        begin
            ip_next = ip_reg + {29'd0, head_item.len};
        end
    end

    // Bank ports: clearing pass, host byte load, or byte, half or word store.
    always_comb
    begin
        for (int k = 0; k < BANKS; k++)
        begin
            logic [1:0]        off;
            logic [ADDR_W-1:0] ba;
            off = 2'(k) - maddr[1:0];
            ba  = maddr + ADDR_W'(off);
            bank_raddr[k] = ba[ADDR_W-1:2];
            bank_we[k]    = 1'b0;
            bank_waddr[k] = ba[ADDR_W-1:2];
            bank_wdata[k] = y[8*off +: 8];
            if (clearing_reg)
            begin
                bank_we[k]    = 1'b1;
                bank_waddr[k] = clr_row_reg;
                bank_wdata[k] = 8'd0;
            end
            else if (commit && head_item.cls == C_HOST)
            begin
                bank_we[k]    = (head_item.load_address[1:0] == 2'(k));
                bank_waddr[k] = head_item.load_address[ADDR_W-1:2];
                bank_wdata[k] = head_item.imm[7:0];
            end
            else if (commit && head_item.cls == C_MOV_MR)
            begin
                bank_we[k] = ({1'b0, off} < nbytes);
            end
        end
    end

    for (genvar g = 0; g < BANKS; g++)
    begin : g_bank
        bcvm_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_waddr[g]),
            .wdata (bank_wdata[g]),
            .re    (rd_issue),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    // Control state, architectural state and the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            clearing_reg  <= 1'b1;
            clr_row_reg   <= '0;
            ip_reg        <= '0;
            zf_reg        <= 1'b0;
            pf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clearing_reg)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                ip_reg        <= ip_next;
                if (!bad)
                begin
                    zf_reg <= zf_next;
                    pf_reg <= pf_next;
                    if (rf_we && {1'b0, head_item.ra} < 5'(NUM_REGS))
                    begin
                        rf_reg[head_item.ra[REG_IDX_W-1:0]] <=
                            (x & ~width_mask(head_item.wa)) |
                            (rf_wval & width_mask(head_item.wa));
                    end
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_ip_reg    <= ip_next;
            out_fault_reg <= bad;
            out_sreq_reg  <= sreq && !bad;
            out_snum_reg  <= sreq ? r0[7:0] : 8'd0;
            out_sarg_reg  <= sreq ? r3 : 32'd0;
            out_zf_reg    <= bad ? zf_reg : zf_next;
            out_pf_reg    <= bad ? pf_reg : pf_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.next_ip          = out_ip_reg;
    assign rsp.fault            = out_fault_reg;
    assign rsp.service_request  = out_sreq_reg;
    assign rsp.service_number   = out_snum_reg;
    assign rsp.service_argument = out_sarg_reg;
    assign rsp.zero_out         = out_zf_reg;
    assign rsp.positive_out     = out_pf_reg;

    assign status.clearing = clearing_reg;
    assign status.ip       = ip_reg;
endmodule
`default_nettype wire

// ===== sv/byte_code_vm_execute_unit.sv =====
// Path: an accepted item is written to the queue, then committed from its head into the result register.
// Throughput: one item per cycle while results are taken; a load from data memory waits at the
// queue head for its data because the banked data memory has a registered read port.
// Reset: registers, IP and flags clear at once; then a clearing pass over all 1024 rows
// zeroes the data memory, one row of all four banks a cycle, with no input taken.
`default_nettype none
module byte_code_vm_execute_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bcvm_in_if.sink    req,
    bcvm_out_if.source rsp
);
    import bcvm_pkg::*;

    logic       push;
    item_t      push_item;
    logic       q_full;
    logic       pop;
    logic       head_valid;
    item_t      head_item;
    bk_status_t status;

    bcvm_front u_front (
        .req       (req),
        .blocked   (status.clearing),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    bcvm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    bcvm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .status     (status),
        .rsp        (rsp)
    );

    // No transfer is taken while the data memory is being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !req.ready)
        else $error("input accepted during memory clear");

    // A faulting item leaves the instruction pointer where it was.
    a_fault_keeps_ip: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.fault |-> rsp.next_ip == status.ip)
        else $error("fault result with moved instruction pointer");

    // A service request never comes with a fault.
    a_sreq_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.service_request |-> !rsp.fault)
        else $error("service request on a faulting item");
endmodule
`default_nettype wire
